/* rtl/tse_pkg.sv */
`timescale 1ns / 1ps

package tse_pkg;

    // parse phases
    localparam logic [4:0] PH_ETH      = 5'd0;
    localparam logic [4:0] PH_IP       = 5'd1;
    localparam logic [4:0] PH_TCP      = 5'd2;
    localparam logic [4:0] PH_REC      = 5'd3;
    localparam logic [4:0] PH_HS       = 5'd4;
    localparam logic [4:0] PH_SID_LEN  = 5'd5;
    localparam logic [4:0] PH_SID      = 5'd6;
    localparam logic [4:0] PH_CS_LEN   = 5'd7;
    localparam logic [4:0] PH_CS       = 5'd8;
    localparam logic [4:0] PH_CM_LEN   = 5'd9;
    localparam logic [4:0] PH_CM       = 5'd10;
    localparam logic [4:0] PH_EXTS_LEN = 5'd11;
    localparam logic [4:0] PH_EXT_TYPE = 5'd12;
    localparam logic [4:0] PH_EXT_LEN  = 5'd13;
    localparam logic [4:0] PH_SNI_HDR  = 5'd14;
    localparam logic [4:0] PH_NAME     = 5'd15;
    localparam logic [4:0] PH_DONE     = 5'd16;

    // status codes
    localparam logic [3:0] ST_FOUND         = 4'd0;
    localparam logic [3:0] ST_NOT_IPV4      = 4'd1;
    localparam logic [3:0] ST_NOT_TCP       = 4'd2;
    localparam logic [3:0] ST_OTHER_PORT    = 4'd3;
    localparam logic [3:0] ST_NOT_HANDSHAKE = 4'd4;
    localparam logic [3:0] ST_NOT_CLIENT_HI = 4'd5;
    localparam logic [3:0] ST_NO_EXTENSIONS = 4'd6;
    localparam logic [3:0] ST_NOT_SNI       = 4'd7;
    localparam logic [3:0] ST_TRUNCATED     = 4'd8;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [15:0] DEFAULT_PORT    = 16'd443;
    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
    localparam logic [15:0] EXT_SERVER_NAME = 16'd0;
    localparam logic [5:0]  MIN_HDR_LEN     = 6'd20;

    typedef struct packed {
        logic [3:0] status;
        logic       packet_done;
        logic       name_last;
        logic [7:0] name_byte;
        logic       name_valid;
    } tse_result_t;

endpackage

/* rtl/tse_parser.sv */
`timescale 1ns / 1ps

module tse_parser
    import tse_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    input  logic [15:0] tls_port,
    output logic        result_valid,
    output tse_result_t result
);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [16:0] SKIP_LIMIT = 17'(2 ** OFFSET_BITS);

    logic [4:0]             phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [15:0]            skip_reg, skip_next;
    logic [7:0]             high_reg, high_next;
    logic [15:0]            names_reg, names_next;
    logic [3:0]             code_reg, code_next;

    logic        moved;
    logic        emit_name;
    logic        name_last;
    logic [15:0] word;
    logic [16:0] idx_p1;
    logic [16:0] skip_ext;
    logic [5:0]  hdr_len;
    logic [15:0] skip_len;
    logic [4:0]  skip_phase;
    logic [4:0]  after_phase;
    logic        skip_go;
    logic [15:0] names_dec;
    logic [3:0]  status;

    assign word     = {high_reg, data_byte};
    assign idx_p1   = 17'(offset_reg) + 17'd1;
    assign skip_ext = {1'b0, skip_reg};
    assign names_dec = names_reg - 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        high_next   = high_reg;
        names_next  = names_reg;
        code_next   = code_reg;
        moved       = 1'b0;
        emit_name   = 1'b0;
        name_last   = 1'b0;
        hdr_len     = '0;
        skip_len    = '0;
        skip_phase  = PH_DONE;
        after_phase = PH_DONE;
        skip_go     = 1'b0;
        status      = ST_FOUND;

        case (phase_reg)
            PH_ETH:
            begin
                if (offset_reg == OFFSET_BITS'(12))
                    high_next = data_byte;
                else if (offset_reg == OFFSET_BITS'(13))
                begin
                    moved = 1'b1;
                    if (word != ETHERTYPE_IPV4)
                    begin
                        code_next  = ST_NOT_IPV4;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_IP;
                end
            end
            PH_IP:
            begin
                if (offset_reg == '0)
                begin
                    hdr_len   = {data_byte[3:0], 2'b00};
                    skip_next = 16'((hdr_len < MIN_HDR_LEN) ? MIN_HDR_LEN : hdr_len);
                end
                if (offset_reg == OFFSET_BITS'(9) && data_byte != PROTO_TCP)
                begin
                    moved      = 1'b1;
                    code_next  = ST_NOT_TCP;
                    phase_next = PH_DONE;
                end
                else if (idx_p1 >= skip_ext && offset_reg >= OFFSET_BITS'(19))
                begin
                    moved      = 1'b1;
                    phase_next = PH_TCP;
                end
            end
            PH_TCP:
            begin
                if (offset_reg == OFFSET_BITS'(2))
                    high_next = data_byte;
                else if (offset_reg == OFFSET_BITS'(12))
                begin
                    hdr_len   = {data_byte[7:4], 2'b00};
                    skip_next = 16'((hdr_len < MIN_HDR_LEN) ? MIN_HDR_LEN : hdr_len);
                end
                if (offset_reg == OFFSET_BITS'(3) && word != tls_port)
                begin
                    moved      = 1'b1;
                    code_next  = ST_OTHER_PORT;
                    phase_next = PH_DONE;
                end
                else if (offset_reg >= OFFSET_BITS'(19) && idx_p1 >= skip_ext)
                begin
                    moved      = 1'b1;
                    phase_next = PH_REC;
                end
            end
            PH_REC:
            begin
                if (offset_reg == '0 && data_byte != REC_HANDSHAKE)
                begin
                    moved      = 1'b1;
                    code_next  = ST_NOT_HANDSHAKE;
                    phase_next = PH_DONE;
                end
                else if (offset_reg == OFFSET_BITS'(4))
                begin
                    moved      = 1'b1;
                    phase_next = PH_HS;
                end
            end
            PH_HS:
            begin
                if (offset_reg == '0 && data_byte != HS_CLIENT_HELLO)
                begin
                    moved      = 1'b1;
                    code_next  = ST_NOT_CLIENT_HI;
                    phase_next = PH_DONE;
                end
                else if (offset_reg == OFFSET_BITS'(37))
                begin
                    moved      = 1'b1;
                    phase_next = PH_SID_LEN;
                end
            end
            PH_SID_LEN:
            begin
                skip_go     = 1'b1;
                skip_len    = {8'd0, data_byte};
                skip_phase  = PH_SID;
                after_phase = PH_CS_LEN;
            end
            PH_CS_LEN:
            begin
                if (offset_reg == '0)
                    high_next = data_byte;
                else
                begin
                    skip_go     = 1'b1;
                    skip_len    = word;
                    skip_phase  = PH_CS;
                    after_phase = PH_CM_LEN;
                end
            end
            PH_CM_LEN:
            begin
                skip_go     = 1'b1;
                skip_len    = {8'd0, data_byte};
                skip_phase  = PH_CM;
                after_phase = PH_EXTS_LEN;
            end
            PH_SID:
            begin
                if (idx_p1 >= skip_ext)
                begin
                    moved      = 1'b1;
                    phase_next = PH_CS_LEN;
                end
            end
            PH_CS:
            begin
                if (idx_p1 >= skip_ext)
                begin
                    moved      = 1'b1;
                    phase_next = PH_CM_LEN;
                end
            end
            PH_CM:
            begin
                if (idx_p1 >= skip_ext)
                begin
                    moved      = 1'b1;
                    phase_next = PH_EXTS_LEN;
                end
            end
            PH_EXTS_LEN:
            begin
                if (offset_reg == '0)
                    high_next = data_byte;
                else
                begin
                    moved = 1'b1;
                    if (word == 16'd0)
                    begin
                        code_next  = ST_NO_EXTENSIONS;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_EXT_TYPE;
                end
            end
            PH_EXT_TYPE:
            begin
                if (offset_reg == '0)
                    high_next = data_byte;
                else
                begin
                    moved = 1'b1;
                    if (word != EXT_SERVER_NAME)
                    begin
                        code_next  = ST_NOT_SNI;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_EXT_LEN;
                end
            end
            PH_EXT_LEN:
            begin
                if (offset_reg == OFFSET_BITS'(1))
                begin
                    moved      = 1'b1;
                    phase_next = PH_SNI_HDR;
                end
            end
            PH_SNI_HDR:
            begin
                if (offset_reg == OFFSET_BITS'(3))
                    high_next = data_byte;
                else if (offset_reg == OFFSET_BITS'(4))
                begin
                    moved      = 1'b1;
                    names_next = word;
                    if (word == 16'd0)
                    begin
                        code_next  = ST_FOUND;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_NAME;
                end
            end
            PH_NAME:
            begin
                emit_name  = 1'b1;
                names_next = names_dec;
                if (names_dec == 16'd0)
                begin
                    name_last  = 1'b1;
                    moved      = 1'b1;
                    code_next  = ST_FOUND;
                    phase_next = PH_DONE;
                end
            end
            default:
                phase_next = PH_DONE;
        endcase

        // start of a counted region: empty goes straight on, overlong cannot be counted
        if (skip_go)
        begin
            moved = 1'b1;
            if (skip_len == 16'd0)
                phase_next = after_phase;
            else if ({1'b0, skip_len} > SKIP_LIMIT)
            begin
                code_next  = ST_TRUNCATED;
                phase_next = PH_DONE;
            end
            else
            begin
                skip_next  = skip_len;
                phase_next = skip_phase;
            end
        end

        if (moved)
            offset_next = '0;
        else if (offset_reg < OFFSET_MAX)
            offset_next = offset_reg + OFFSET_BITS'(1);
        else
            offset_next = offset_reg;

        if (end_of_packet)
        begin
            status      = (phase_next == PH_DONE) ? code_next : ST_TRUNCATED;
            phase_next  = PH_ETH;
            offset_next = '0;
            skip_next   = '0;
            high_next   = '0;
            names_next  = '0;
            code_next   = ST_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ETH;
            offset_reg <= '0;
            skip_reg   <= '0;
            high_reg   <= '0;
            names_reg  <= '0;
            code_reg   <= ST_FOUND;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            skip_reg   <= skip_next;
            high_reg   <= high_next;
            names_reg  <= names_next;
            code_reg   <= code_next;
        end
    end

    assign result_valid       = step && (emit_name || end_of_packet);
    assign result.name_valid  = emit_name;
    assign result.name_byte   = emit_name ? data_byte : 8'd0;
    assign result.name_last   = name_last;
    assign result.packet_done = end_of_packet;
    assign result.status      = end_of_packet ? status : ST_FOUND;

endmodule

/* rtl/tls_sni_extractor_unit.sv */
`timescale 1ns / 1ps

// TLS server name extractor.
// Slave stream: one frame byte per request in s_tdata, s_tlast on the final
// byte. Master stream: a result for each server name byte and one closing
// each frame (m_tlast), carrying the status code.
// APB port: one register, tls_port at address 0 (reset 443), to be written by the user
// only while no frame is in flight; the block itself does not enforce this.
// Throughput: one byte per cycle while s_tready is high. Each byte is parsed in the
// cycle it is accepted by the phase/offset logic in tse_parser; its result
// is registered in the output register, or in the skid entry while that is stalled.
// A two-entry output buffer (output register plus skid) lets the input run
// on while a result waits; s_tready drops only when both entries are full,
// and a stalled receiver holds the front result steady.
// Reset returns the parser to the Ethernet header, empties the buffer and
// loads tls_port with 443.
module tls_sni_extractor_unit
    import tse_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] name_valid, [8:1] name_byte, [9] name_last,
                                   // [13:10] status, [15:14] zero
    output logic        m_tlast    // packet_done
);

    localparam logic [2:0] ADDR_TLS_PORT = 3'd0;

    logic [15:0] tls_port_reg;
    logic        step;
    logic        res_valid;
    tse_result_t res;

    tse_result_t out_data_reg, skid_data_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        out_free;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TLS_PORT) ? {16'd0, tls_port_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tls_port_reg <= DEFAULT_PORT;
        else if (psel && penable && pwrite && pready && paddr == ADDR_TLS_PORT)
            tls_port_reg <= pwdata[15:0];
    end

    assign s_tready = !skid_valid_reg;
    assign step     = s_tvalid && s_tready;

    tse_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (s_tdata),
        .end_of_packet(s_tlast),
        .tls_port     (tls_port_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= res_valid;
        end
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        else if (res_valid)
            skid_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg.status, out_data_reg.name_last,
                       out_data_reg.name_byte, out_data_reg.name_valid};
    assign m_tlast  = out_data_reg.packet_done;

endmodule

/* rtl/tse_checker.sv */
`timescale 1ns / 1ps

module tse_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

    // last-name mark only on a name byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] |-> m_tdata[0])
    else $error("name_last without name_valid");

    // status only on the closing result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[13:10] == 4'd0)
    else $error("status outside packet close");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[13:10] <= 4'd8 && m_tdata[15:14] == 2'b00)
    else $error("status code out of range");

endmodule

bind tls_sni_extractor_unit tse_checker u_tse_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .pready  (pready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

/* dv/tb_tls_sni_extractor_unit.sv */
`timescale 1ns / 1ps

module tb_tls_sni_extractor_unit;
    import tse_pkg::*;

    localparam int          OFFSET_BITS    = 16;
    localparam int unsigned OFFSET_MAX     = (1 << OFFSET_BITS) - 1;
    localparam logic [2:0]  REG_TLS_PORT   = 3'd0;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          PHASE_BYTES    = 465;

    typedef enum int {
        BAD_ETHERTYPE,
        BAD_PROTO,
        BAD_PORT,
        BAD_RECORD,
        BAD_HS_TYPE,
        NO_EXTS,
        BAD_EXT_TYPE,
        EMPTY_NAME
    } defect_t;

    typedef struct {
        logic [15:0] ethertype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] dport;
        logic [3:0]  doff;
        logic [7:0]  rec_type;
        logic [7:0]  hs_type;
        logic [7:0]  sid_len;
        logic [15:0] cs_len;
        logic [7:0]  cm_len;
        logic [15:0] exts_len;
        logic [15:0] ext_type;
        logic [15:0] name_len;
        int          tail_len;
    } hello_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;   // end_of_packet
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [0] name_valid, [8:1] name_byte, [9] name_last,
                            // [13:10] status, [15:14] zero
    logic        m_tlast;   // packet_done

    logic        hold_on = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // parser mirror
    logic [15:0] sni_port;
    logic [4:0]  prs_phase;
    int unsigned prs_offset;
    logic [15:0] prs_region;
    logic [7:0]  prs_high;
    logic [15:0] prs_names_left;
    logic [3:0]  prs_code;
    bit          prs_moved;

    tse_result_t expected_results[$];
    logic [7:0]  frame_bytes[$];

    int mismatches = 0;
    int n_frames = 0;
    int n_bytes = 0;
    int n_results = 0;
    int n_found = 0;
    int quiet_cycles = 0;

    tls_sni_extractor_unit #(.OFFSET_BITS(OFFSET_BITS)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic void enter_phase(logic [4:0] ph);
        prs_phase  = ph;
        prs_offset = 0;
        prs_moved  = 1'b1;
    endfunction

    function automatic void stop_with(logic [3:0] code);
        prs_code = code;
        enter_phase(PH_DONE);
    endfunction

    function automatic void open_region(int unsigned len, logic [4:0] skip_ph,
                                        logic [4:0] next_ph);
        if (len == 0)
            enter_phase(next_ph);
        else if (len > OFFSET_MAX + 1)
            stop_with(ST_TRUNCATED);
        else
        begin
            prs_region = len[15:0];
            enter_phase(skip_ph);
        end
    endfunction

    function automatic void clear_parser();
        prs_phase      = PH_ETH;
        prs_offset     = 0;
        prs_region     = '0;
        prs_high       = '0;
        prs_names_left = '0;
        prs_code       = ST_FOUND;
    endfunction

    function automatic void parse_sni_byte(logic [7:0] b, logic eop);
        int unsigned idx;
        int unsigned hdr;
        logic [15:0] word;
        tse_result_t res;
        bit          emit;
        idx = prs_offset;
        word = {prs_high, b};
        res = '0;
        emit = 1'b0;
        prs_moved = 1'b0;
        case (prs_phase)
            PH_ETH:
                if (idx == 12)
                    prs_high = b;
                else if (idx == 13)
                begin
                    if (word != ETHERTYPE_IPV4)
                        stop_with(ST_NOT_IPV4);
                    else
                        enter_phase(PH_IP);
                end
            PH_IP:
                if (idx == 9 && b != PROTO_TCP)
                    stop_with(ST_NOT_TCP);
                else
                begin
                    if (idx == 0)
                    begin
                        hdr = 4 * int'(b[3:0]);
                        prs_region = (hdr < 20) ? 16'd20 : hdr[15:0];
                    end
                    if (idx + 1 >= prs_region && idx >= 19)
                        enter_phase(PH_TCP);
                end
            PH_TCP:
                if (idx == 3 && word != sni_port)
                    stop_with(ST_OTHER_PORT);
                else
                begin
                    if (idx == 2)
                        prs_high = b;
                    else if (idx == 12)
                    begin
                        hdr = 4 * int'(b[7:4]);
                        prs_region = (hdr < 20) ? 16'd20 : hdr[15:0];
                    end
                    if (idx >= 19 && idx + 1 >= prs_region)
                        enter_phase(PH_REC);
                end
            PH_REC:
                if (idx == 0 && b != REC_HANDSHAKE)
                    stop_with(ST_NOT_HANDSHAKE);
                else if (idx == 4)
                    enter_phase(PH_HS);
            PH_HS:
                if (idx == 0 && b != HS_CLIENT_HELLO)
                    stop_with(ST_NOT_CLIENT_HI);
                else if (idx == 37)
                    enter_phase(PH_SID_LEN);
            PH_SID_LEN:
                open_region(b, PH_SID, PH_CS_LEN);
            PH_CS_LEN:
                if (idx == 0)
                    prs_high = b;
                else
                    open_region(word, PH_CS, PH_CM_LEN);
            PH_CM_LEN:
                open_region(b, PH_CM, PH_EXTS_LEN);
            PH_SID:
                if (idx + 1 >= prs_region)
                    enter_phase(PH_CS_LEN);
            PH_CS:
                if (idx + 1 >= prs_region)
                    enter_phase(PH_CM_LEN);
            PH_CM:
                if (idx + 1 >= prs_region)
                    enter_phase(PH_EXTS_LEN);
            PH_EXTS_LEN:
                if (idx == 0)
                    prs_high = b;
                else if (word == 0)
                    stop_with(ST_NO_EXTENSIONS);
                else
                    enter_phase(PH_EXT_TYPE);
            PH_EXT_TYPE:
                if (idx == 0)
                    prs_high = b;
                else if (word != EXT_SERVER_NAME)
                    stop_with(ST_NOT_SNI);
                else
                    enter_phase(PH_EXT_LEN);
            PH_EXT_LEN:
                if (idx == 1)
                    enter_phase(PH_SNI_HDR);
            PH_SNI_HDR:
                if (idx == 3)
                    prs_high = b;
                else if (idx == 4)
                begin
                    prs_names_left = word;
                    if (word == 0)
                        stop_with(ST_FOUND);
                    else
                        enter_phase(PH_NAME);
                end
            PH_NAME:
            begin
                emit = 1'b1;
                res.name_valid = 1'b1;
                res.name_byte = b;
                prs_names_left = prs_names_left - 16'd1;
                if (prs_names_left == 0)
                begin
                    res.name_last = 1'b1;
                    stop_with(ST_FOUND);
                end
            end
            default:
                prs_phase = PH_DONE;
        endcase

        if (!prs_moved && prs_offset < OFFSET_MAX)
            prs_offset++;

        if (eop)
        begin
            emit = 1'b1;
            res.packet_done = 1'b1;
            res.status = (prs_phase == PH_DONE) ? prs_code : ST_TRUNCATED;
            if (res.status == ST_FOUND)
                n_found++;
            clear_parser();
        end

        if (emit)
            expected_results.push_back(res);
    endfunction

    // ---------------- frame construction ----------------

    function automatic hello_t random_hello();
        hello_t h;
        h.ethertype = ETHERTYPE_IPV4;
        h.ihl       = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd5;
        h.proto     = PROTO_TCP;
        h.dport     = sni_port;
        h.doff      = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd5;
        h.rec_type  = REC_HANDSHAKE;
        h.hs_type   = HS_CLIENT_HELLO;
        h.sid_len   = ($urandom_range(7) == 0) ? 8'd32 : 8'($urandom_range(6));
        h.cs_len    = 16'($urandom_range(8));
        h.cm_len    = 8'($urandom_range(2));
        h.exts_len  = 16'($urandom_range(1, 65535));
        h.ext_type  = EXT_SERVER_NAME;
        h.name_len  = 16'($urandom_range(1, 12));
        h.tail_len  = $urandom_range(1) ? $urandom_range(1, 6) : 0;
        return h;
    endfunction

    function automatic hello_t break_field(hello_t h, defect_t which);
        case (which)
            BAD_ETHERTYPE: h.ethertype ^= 16'($urandom_range(1, 65535));
            BAD_PROTO:     h.proto     ^= 8'($urandom_range(1, 255));
            BAD_PORT:      h.dport     ^= 16'($urandom_range(1, 65535));
            BAD_RECORD:    h.rec_type  ^= 8'($urandom_range(1, 255));
            BAD_HS_TYPE:   h.hs_type   ^= 8'($urandom_range(1, 255));
            NO_EXTS:       h.exts_len   = 16'd0;
            BAD_EXT_TYPE:  h.ext_type  ^= 16'($urandom_range(1, 65535));
            default:       h.name_len   = 16'd0;
        endcase
        return h;
    endfunction

    function automatic void add_random(int n);
        for (int i = 0; i < n; i++)
            frame_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_frame(hello_t h);
        int          ip_len;
        int          tcp_len;
        logic [3:0]  nib;
        frame_bytes.delete();
        add_random(12);
        frame_bytes.push_back(h.ethertype[15:8]);
        frame_bytes.push_back(h.ethertype[7:0]);
        ip_len = (h.ihl < 5) ? 20 : 4 * int'(h.ihl);
        for (int i = 0; i < ip_len; i++)
        begin
            nib = 4'($urandom_range(15));
            if (i == 0)
                frame_bytes.push_back({nib, h.ihl});
            else if (i == 9)
                frame_bytes.push_back(h.proto);
            else
                add_random(1);
        end
        tcp_len = (h.doff < 5) ? 20 : 4 * int'(h.doff);
        for (int i = 0; i < tcp_len; i++)
        begin
            nib = 4'($urandom_range(15));
            if (i == 2)
                frame_bytes.push_back(h.dport[15:8]);
            else if (i == 3)
                frame_bytes.push_back(h.dport[7:0]);
            else if (i == 12)
                frame_bytes.push_back({h.doff, nib});
            else
                add_random(1);
        end
        frame_bytes.push_back(h.rec_type);
        add_random(4);
        frame_bytes.push_back(h.hs_type);
        add_random(37);
        frame_bytes.push_back(h.sid_len);
        add_random(h.sid_len);
        frame_bytes.push_back(h.cs_len[15:8]);
        frame_bytes.push_back(h.cs_len[7:0]);
        add_random(h.cs_len);
        frame_bytes.push_back(h.cm_len);
        add_random(h.cm_len);
        frame_bytes.push_back(h.exts_len[15:8]);
        frame_bytes.push_back(h.exts_len[7:0]);
        frame_bytes.push_back(h.ext_type[15:8]);
        frame_bytes.push_back(h.ext_type[7:0]);
        add_random(2);      // extension length, never checked
        add_random(3);      // list length and name type
        frame_bytes.push_back(h.name_len[15:8]);
        frame_bytes.push_back(h.name_len[7:0]);
        add_random(h.name_len);
        add_random(h.tail_len);
    endfunction

    // ---------------- bus tasks ----------------

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        n_bytes++;
        parse_sni_byte(b, last);
    endtask

    // cut of 0 or of at least the frame size sends the whole frame, otherwise the frame ends after cut bytes
    task automatic send_frame(input int cut);
        int len;
        len = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
        for (int i = 0; i < len; i++)
            send_byte(frame_bytes[i], i == len - 1);
        n_frames++;
    endtask

    task automatic send_hello(input hello_t h, input int cut);
        build_frame(h);
        send_frame(cut);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_TLS_PORT)
            sni_port = data[15:0];
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_port_readback();
        logic [31:0] rd;
        apb_read(REG_TLS_PORT, rd);
        if (rd[15:0] !== sni_port)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("tls_port readback: expected %0d, got %0d", sni_port, rd[15:0]);
        end
    endtask

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin : result_check
        tse_result_t got;
        tse_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.name_valid  = m_tdata[0];
            got.name_byte   = m_tdata[8:1];
            got.name_last   = m_tdata[9];
            got.status      = m_tdata[13:10];
            got.packet_done = m_tlast;
            n_results++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: valid=%0b byte=%02h last=%0b done=%0b st=%0d",
                             got.name_valid, got.name_byte, got.name_last,
                             got.packet_done, got.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.name_valid !== want.name_valid || got.name_byte !== want.name_byte ||
                    got.name_last !== want.name_last ||
                    got.packet_done !== want.packet_done || got.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected v=%0b b=%02h l=%0b d=%0b st=%0d, %s",
                                 n_results, want.name_valid, want.name_byte, want.name_last,
                                 want.packet_done, want.status,
                                 $sformatf("got v=%0b b=%02h l=%0b d=%0b st=%0d",
                                           got.name_valid, got.name_byte, got.name_last,
                                           got.packet_done, got.status));
                end
            end
        end
    end

    // receiver side; hold_on forces a long stall
    always @(posedge clk)
    begin
        if (hold_on)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_config_access();
        check_port_readback();
        apb_write(REG_TLS_PORT, 32'd65535);
        check_port_readback();
        apb_write(REG_TLS_PORT, 32'd0);
        check_port_readback();
        apb_write(REG_TLS_PORT, 32'(DEFAULT_PORT));
        check_port_readback();
    endtask

    task automatic test_status_codes();
        defect_t d;
        send_hello(random_hello(), 0);
        d = d.first();
        do
        begin
            send_hello(break_field(random_hello(), d), 0);
            d = d.next();
        end
        while (d != d.first());
        build_frame(random_hello());
        send_frame($urandom_range(1, frame_bytes.size() - 1));
        wait_idle();
    endtask

    task automatic test_header_lengths();
        logic [3:0] ihl_set[4] = '{4'd0, 4'd4, 4'd5, 4'd15};
        logic [3:0] doff_set[3] = '{4'd0, 4'd4, 4'd15};
        hello_t h;
        foreach (ihl_set[i])
        begin
            h = random_hello();
            h.ihl = ihl_set[i];
            h.doff = 4'd5;
            send_hello(h, 0);
        end
        foreach (doff_set[i])
        begin
            h = random_hello();
            h.ihl = 4'd5;
            h.doff = doff_set[i];
            send_hello(h, 0);
        end
        wait_idle();
    endtask

    task automatic test_frame_edges();
        hello_t h;
        frame_bytes.delete();
        add_random(1);
        send_frame(0);
        // decision lands on the final byte
        send_hello(break_field(random_hello(), BAD_ETHERTYPE), 14);
        send_hello(random_hello(), 14);
        h = break_field(random_hello(), BAD_PORT);
        h.ihl = 4'd5;
        send_hello(h, 14 + 20 + 4);
        // name cut short, then a name ending exactly on the final byte
        h = random_hello();
        h.name_len = 16'd8;
        h.tail_len = 0;
        build_frame(h);
        send_frame(frame_bytes.size() - 3);
        send_hello(h, 0);
        h.name_len = 16'd1;
        send_hello(h, 0);
        h.tail_len = 20;
        send_hello(h, 0);
        wait_idle();
    endtask

    task automatic test_long_regions();
        hello_t h;
        h = random_hello();
        h.sid_len = 8'd255;
        h.cm_len = 8'd255;
        h.exts_len = 16'd65535;
        send_hello(h, 0);
        h = random_hello();
        h.sid_len = 8'd0;
        h.cs_len = 16'd0;
        h.cm_len = 8'd0;
        h.exts_len = 16'd1;
        h.name_len = 16'd300;
        send_hello(h, 0);
        h = random_hello();
        h.cs_len = 16'd65535;
        h.ext_type = 16'hFFFF;
        send_hello(h, 0);
        h = random_hello();
        h.cs_len = 16'd65535;
        send_hello(h, 0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        hello_t h;
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        for (int i = 0; i < 3; i++)
        begin
            h = random_hello();
            h.name_len = 16'd12;
            send_hello(h, 0);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [15:0] port);
        int     start;
        int     pick;
        hello_t h;
        apb_write(REG_TLS_PORT, {16'd0, port});
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = n_bytes;
        while (n_bytes - start < PHASE_BYTES)
        begin
            pick = $urandom_range(99);
            h = random_hello();
            if (pick < 60)
                send_hello(h, 0);
            else if (pick < 80)
                send_hello(break_field(h, defect_t'($urandom_range(EMPTY_NAME))), 0);
            else if (pick < 90)
            begin
                build_frame(h);
                send_frame($urandom_range(1, frame_bytes.size() - 1));
            end
            else
            begin
                frame_bytes.delete();
                add_random($urandom_range(1, 40));
                send_frame(0);
            end
        end
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        sni_port = DEFAULT_PORT;
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_config_access();
        test_status_codes();
        test_header_lengths();
        test_frame_edges();
        test_long_regions();
        test_backpressure();
        test_random_traffic(0, 0, DEFAULT_PORT);
        test_random_traffic(65, 0, 16'd0);
        test_random_traffic(0, 65, 16'd65535);
        test_random_traffic(24, 24, 16'($urandom_range(65535)));

        if (expected_results.size() != 0)
            mismatches++;
        $display("Run covered %0d frames (%0d bytes), %0d results, %0d names found",
                 n_frames, n_bytes, n_results, n_found);
        $display("Every status code, odd header lengths, cut frames, long regions, "
                 , "a receiver hold-off and four port/idle settings were exercised");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
